// ===== rtl/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and codes for the max priority queue: operation and status
// codes, controller states and the control bundle sent to the cell row.
// ----------------------------------------------------------------------------
package hpq_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 7;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic {
        S_IDLE,
        S_REPORT
    } state_t;

    typedef struct packed {
        logic insert_en;
        logic remove_en;
    } cell_ctrl_t;

endpackage

// ===== rtl/max_heap_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core
// The request updates the cell row, count and status registers; the report
// state then reads the head slot into the output register. A new request is
// not accepted during the report state or while an unaccepted result is held.
// Reset: clears the element count, the controller and the output valid flag;
// slot contents are not cleared and only occupied slots are ever reported.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_core #(
    parameter int unsigned CAPACITY = 127
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_operation,
    input  logic signed [31:0]               s_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [hpq_pkg::STATUS_W-1:0]     m_status,
    output logic signed [31:0]               m_removed_value,
    output logic signed [31:0]               m_top_value,
    output logic [hpq_pkg::COUNT_W-1:0]      m_count
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    hpq_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [hpq_pkg::STATUS_W-1:0] status_reg, status_next;
    hpq_pkg::value_t removed_reg, removed_next;

    logic m_valid_reg, m_valid_next;
    logic [hpq_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    hpq_pkg::value_t m_removed_value_reg, m_removed_value_next;
    hpq_pkg::value_t m_top_value_reg, m_top_value_next;
    logic [hpq_pkg::COUNT_W-1:0] m_count_reg, m_count_next;

    hpq_pkg::cell_ctrl_t ctrl;
    hpq_pkg::value_t     cell_value [CAPACITY];
    logic                cell_greater [CAPACITY];

    logic s_fire;
    logic full;
    logic empty;
    logic [CNT_W+hpq_pkg::COUNT_W-1:0] count_ext;

    assign s_fire = s_valid && s_ready;
    assign full   = (count_reg == CAP_C);
    assign empty  = (count_reg == '0);

    // ---------------------------------------------------------------- cell row
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        hpq_pkg::value_t prev_v;
        hpq_pkg::value_t next_v;
        logic            prev_g;

        if (i == 0) begin : g_head
            assign prev_v = '0;
            assign prev_g = 1'b0;
        end else begin : g_body
            assign prev_v = cell_value[i-1];
            assign prev_g = cell_greater[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign next_v = '0;
        end else begin : g_inner
            assign next_v = cell_value[i+1];
        end

        hpq_cell u_cell (
            .aclk         (aclk),
            .ctrl         (ctrl),
            .new_value    (s_value),
            .prev_value   (prev_v),
            .prev_greater (prev_g),
            .next_value   (next_v),
            .occupied     (IDX < count_reg),
            .value        (cell_value[i]),
            .greater      (cell_greater[i])
        );
    end

    // ---------------------------------------------------------- state machine
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hpq_pkg::S_IDLE:   if (s_fire) state_next = hpq_pkg::S_REPORT;
            hpq_pkg::S_REPORT: state_next = hpq_pkg::S_IDLE;
            default:           state_next = hpq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = (state_reg == hpq_pkg::S_IDLE) && (!m_valid_reg || m_ready);
        ctrl.insert_en = s_fire && (s_operation == hpq_pkg::OP_INSERT) && !full;
        ctrl.remove_en = s_fire && (s_operation == hpq_pkg::OP_REMOVE) && !empty;
    end

    // --------------------------------------------------------- datapath/result
    assign count_ext = {{hpq_pkg::COUNT_W{1'b0}}, count_reg};

    always_comb begin
        count_next           = count_reg;
        status_next          = status_reg;
        removed_next         = removed_reg;
        m_valid_next         = m_valid_reg;
        m_status_next        = m_status_reg;
        m_removed_value_next = m_removed_value_reg;
        m_top_value_next     = m_top_value_reg;
        m_count_next         = m_count_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s_fire) begin
            status_next  = hpq_pkg::ST_OK;
            removed_next = '0;
            if (s_operation == hpq_pkg::OP_INSERT) begin
                if (full) begin
                    status_next = hpq_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end else begin
                if (empty) begin
                    status_next = hpq_pkg::ST_EMPTY;
                end else begin
                    removed_next = cell_value[0];
                    count_next   = count_reg - 1'b1;
                end
            end
        end

        // head slot holds the largest element once the row has settled
        if (state_reg == hpq_pkg::S_REPORT) begin
            m_valid_next         = 1'b1;
            m_status_next        = status_reg;
            m_removed_value_next = removed_reg;
            m_top_value_next     = empty ? '0 : cell_value[0];
            m_count_next         = count_ext[hpq_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hpq_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg          <= status_next;
        removed_reg         <= removed_next;
        m_status_reg        <= m_status_next;
        m_removed_value_reg <= m_removed_value_next;
        m_top_value_reg     <= m_top_value_next;
        m_count_reg         <= m_count_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_removed_value = m_removed_value_reg;
    assign m_top_value     = m_top_value_reg;
    assign m_count         = m_count_reg;

endmodule

// ===== rtl/hpq_cell.sv =====
// ----------------------------------------------------------------------------
// hpq_cell
// One slot of the sorted row. Slots are kept in descending order; on insert
// a slot shifts its value down the row or takes the new value, on remove it
// takes the value of the slot after it.
// ----------------------------------------------------------------------------
module hpq_cell (
    input  logic                aclk,
    input  hpq_pkg::cell_ctrl_t ctrl,
    input  hpq_pkg::value_t     new_value,
    input  hpq_pkg::value_t     prev_value,
    input  logic                prev_greater,
    input  hpq_pkg::value_t     next_value,
    input  logic                occupied,
    output hpq_pkg::value_t     value,
    output logic                greater
);

    hpq_pkg::value_t value_reg;
    hpq_pkg::value_t value_next;

    // an empty slot ranks below any value
    assign greater = !occupied || (new_value > value_reg);
    assign value   = value_reg;

    always_comb begin
        value_next = value_reg;
        if (ctrl.insert_en && greater) begin
            // the slot before also moved down, so take its old value
            value_next = prev_greater ? prev_value : new_value;
        end else if (ctrl.remove_en) begin
            value_next = next_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule
